[hdl/pps_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, sequencer states and helper functions for the palette packed store.
package pps_pkg;

  localparam int POSITIONS   = 4096;
  localparam int PALETTE_MAX = 65536;
  localparam int ID_BITS     = 20;
  localparam int POS_BITS    = 12;
  localparam int PK_AW       = $clog2(POSITIONS);
  localparam int PAL_AW      = $clog2(PALETTE_MAX);
  localparam int CNT_BITS    = PAL_AW + 1;
  localparam int WORD_BITS   = 16;

  localparam logic [2:0] MODE_AIR     = 3'd0;
  localparam logic [2:0] MODE_ONE     = 3'd1;
  localparam logic [2:0] MODE_SIXTEEN = 3'd5;
  localparam logic [2:0] MODE_DIRECT  = 3'd6;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_AIR_ENT,
    S_APPEND,
    S_PK_RD,
    S_PK_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_WID_RD,
    S_WID_LO,
    S_WID_HI,
    S_DIR_RD,
    S_DIR_PAL,
    S_DIR_WR,
    S_DIR_SET,
    S_RD_PK,
    S_RD_PAL,
    S_RD_PALD,
    S_RD_DIR,
    S_RD_DIRD,
    S_DONE
  } state_t;

  // Field mask for 1 << lb bits per position.
  function automatic logic [WORD_BITS-1:0] field_mask(input logic [2:0] lb);
    logic [WORD_BITS-1:0] m;
    case (lb)
      3'd0:    m = 16'h0001;
      3'd1:    m = 16'h0003;
      3'd2:    m = 16'h000F;
      3'd3:    m = 16'h00FF;
      default: m = 16'hFFFF;
    endcase
    return m;
  endfunction

  // Spread the fields of one half word to double width.
  function automatic logic [WORD_BITS-1:0] widen_half(input logic [7:0] h,
                                                      input logic [2:0] lb);
    logic [WORD_BITS-1:0] w;
    w = '0;
    case (lb)
      3'd0: begin
        for (int k = 0; k < 8; k++) w[2*k +: 2] = {1'b0, h[k]};
      end
      3'd1: begin
        for (int k = 0; k < 4; k++) w[4*k +: 4] = {2'b00, h[2*k +: 2]};
      end
      3'd2: begin
        for (int k = 0; k < 2; k++) w[8*k +: 8] = {4'h0, h[4*k +: 4]};
      end
      default: w = {8'h00, h};
    endcase
    return w;
  endfunction

endpackage

[hdl/pps_ram.sv]
`timescale 1ns / 1ps
// Generic single-port RAM with registered read; read data holds during writes.
module pps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/palette_packed_store_core.sv]
`timescale 1ns / 1ps
// Top level of the palette packed store: sequencer, packed, palette and direct memories.
//
// Usage: one item (cmd, pos, state_id) is taken per in_valid/in_ready transfer and
// gives exactly one result (read_state, mode, palette_count) on the out channel.
// in_ready is high only while the sequencer is idle; one item is worked at a time.
// The result sits in an output register, so a new item is taken while it waits.
// cfg_data sets the air id; cfg_ready is always high.
// Steps per item, all paced by the single-port memories:
//   read: none (air), direct read (direct), packed then palette read (paletted); direct write: one write.
//   paletted write: a read and compare per palette entry searched, an append of a new id,
//   then a read-modify-write of the packed word.
//   leaving all-air mode: a clearing pass that writes zero to all POSITIONS packed words.
//   widening: a read, a low-half and a high-half write per old word, repacking in place from the top.
//   switch to direct ids: per position a packed read, palette read and direct write.
// Reset returns the store to all-air mode with an empty palette and air id zero.
// When the output register is full and out_ready is low, the sequencer holds its finished
// result until the output register frees up.
module palette_packed_store_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pps_pkg::ID_BITS-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [pps_pkg::POS_BITS-1:0]   pos,
  input  logic [pps_pkg::ID_BITS-1:0]    state_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pps_pkg::ID_BITS-1:0]    read_state,
  output logic [2:0]                     mode,
  output logic [pps_pkg::CNT_BITS-1:0]   palette_count
);

  import pps_pkg::*;

  state_t state, state_next;

  logic [ID_BITS-1:0]   air_r;
  logic                 cmd_r;
  logic [POS_BITS-1:0]  pos_r;
  logic [ID_BITS-1:0]   id_r;
  logic [2:0]           mode_r;
  logic [CNT_BITS-1:0]  used;
  logic [CNT_BITS-1:0]  cnt;
  logic [PAL_AW-1:0]    idx_r;
  logic [ID_BITS-1:0]   rd;

  logic                 pk_we, pal_we, dir_we;
  logic [PK_AW-1:0]     pk_addr, dir_addr;
  logic [PAL_AW-1:0]    pal_addr;
  logic [WORD_BITS-1:0] pk_wdata, pk_rdata;
  logic [ID_BITS-1:0]   pal_wdata, pal_rdata, dir_wdata, dir_rdata;

  logic [2:0]           lb;
  logic [WORD_BITS-1:0] bitpos;
  logic [PK_AW-1:0]     pk_w;
  logic [3:0]           pk_sh;
  logic [WORD_BITS-1:0] msk;
  logic [PAL_AW-1:0]    idx_ext;
  logic [WORD_BITS-1:0] merged;
  logic [CNT_BITS-1:0]  cap;
  logic                 out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // Packed-word addressing for the current width.
  assign lb      = mode_r - 3'd1;
  assign bitpos  = WORD_BITS'({4'h0, pos_r} << lb);
  assign pk_w    = bitpos[WORD_BITS-1:4];
  assign pk_sh   = bitpos[3:0];
  assign msk     = field_mask(lb);
  assign idx_ext = PAL_AW'((pk_rdata >> pk_sh) & msk);
  assign merged  = (pk_rdata & ~(msk << pk_sh)) | ((WORD_BITS'(idx_r) & msk) << pk_sh);
  assign cap     = CNT_BITS'(1) << (5'd1 << lb);

  pps_ram #(.WIDTH(WORD_BITS), .DEPTH(POSITIONS)) u_packed (
    .clk(clk), .we(pk_we), .addr(pk_addr), .wdata(pk_wdata), .rdata(pk_rdata)
  );

  pps_ram #(.WIDTH(ID_BITS), .DEPTH(PALETTE_MAX)) u_palette (
    .clk(clk), .we(pal_we), .addr(pal_addr), .wdata(pal_wdata), .rdata(pal_rdata)
  );

  pps_ram #(.WIDTH(ID_BITS), .DEPTH(POSITIONS)) u_direct (
    .clk(clk), .we(dir_we), .addr(dir_addr), .wdata(dir_wdata), .rdata(dir_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_WRITE) begin
            if (mode_r == MODE_DIRECT) state_next = S_DIR_SET;
            else if (mode_r == MODE_AIR) state_next = (state_id == air_r) ? S_DONE : S_CLEAR;
            else state_next = S_SRCH_RD;
          end else begin
            if (mode_r == MODE_AIR) state_next = S_DONE;
            else if (mode_r == MODE_DIRECT) state_next = S_RD_DIR;
            else state_next = S_RD_PK;
          end
        end
      end
      S_CLEAR:    if (cnt == CNT_BITS'(POSITIONS - 1)) state_next = S_AIR_ENT;
      S_AIR_ENT:  state_next = S_APPEND;
      S_APPEND:   state_next = S_PK_RD;
      S_PK_RD:    state_next = S_PK_WR;
      S_PK_WR:    state_next = S_DONE;
      S_SRCH_RD: begin
        if (cnt >= used) begin
          if (mode_r == MODE_SIXTEEN) begin
            state_next = (used >= CNT_BITS'(PALETTE_MAX)) ? S_DIR_RD : S_APPEND;
          end else begin
            state_next = (used >= cap) ? S_WID_RD : S_APPEND;
          end
        end else begin
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: state_next = (pal_rdata == id_r) ? S_PK_RD : S_SRCH_RD;
      S_WID_RD:   state_next = S_WID_LO;
      S_WID_LO:   state_next = S_WID_HI;
      S_WID_HI:   state_next = (cnt == '0) ? S_APPEND : S_WID_RD;
      S_DIR_RD:   state_next = S_DIR_PAL;
      S_DIR_PAL:  state_next = S_DIR_WR;
      S_DIR_WR:   state_next = (cnt == CNT_BITS'(POSITIONS - 1)) ? S_DIR_SET : S_DIR_RD;
      S_DIR_SET:  state_next = S_DONE;
      S_RD_PK:    state_next = S_RD_PAL;
      S_RD_PAL:   state_next = (CNT_BITS'(idx_ext) >= used) ? S_DONE : S_RD_PALD;
      S_RD_PALD:  state_next = S_DONE;
      S_RD_DIR:   state_next = S_RD_DIRD;
      S_RD_DIRD:  state_next = S_DONE;
      S_DONE:     if (out_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    pk_we     = 1'b0;
    pk_addr   = pk_w;
    pk_wdata  = merged;
    pal_we    = 1'b0;
    pal_addr  = cnt[PAL_AW-1:0];
    pal_wdata = id_r;
    dir_we    = 1'b0;
    dir_addr  = pos_r;
    dir_wdata = id_r;
    case (state)
      S_CLEAR: begin
        pk_we    = 1'b1;
        pk_addr  = cnt[PK_AW-1:0];
        pk_wdata = '0;
      end
      S_AIR_ENT: begin
        pal_we    = 1'b1;
        pal_addr  = '0;
        pal_wdata = air_r;
      end
      S_APPEND: begin
        pal_we   = 1'b1;
        pal_addr = used[PAL_AW-1:0];
      end
      S_PK_WR:   pk_we = 1'b1;
      S_WID_RD:  pk_addr = cnt[PK_AW-1:0];
      S_WID_LO: begin
        pk_we    = 1'b1;
        pk_addr  = {cnt[PK_AW-2:0], 1'b0};
        pk_wdata = widen_half(pk_rdata[7:0], lb);
      end
      S_WID_HI: begin
        pk_we    = 1'b1;
        pk_addr  = {cnt[PK_AW-2:0], 1'b1};
        pk_wdata = widen_half(pk_rdata[15:8], lb);
      end
      S_DIR_RD:  pk_addr = cnt[PK_AW-1:0];
      S_DIR_PAL: pal_addr = PAL_AW'(pk_rdata);
      S_DIR_WR: begin
        dir_we    = 1'b1;
        dir_addr  = cnt[PK_AW-1:0];
        dir_wdata = pal_rdata;
      end
      S_DIR_SET: dir_we = 1'b1;
      S_RD_PAL:  pal_addr = idx_ext;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      air_r     <= '0;
      mode_r    <= MODE_AIR;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) air_r <= cfg_data;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_AIR_ENT: begin
          mode_r <= MODE_ONE;
          used   <= CNT_BITS'(1);
        end
        S_APPEND:  used <= used + CNT_BITS'(1);
        S_WID_HI:  if (cnt == '0) mode_r <= mode_r + 3'd1;
        S_DIR_WR: begin
          if (cnt == CNT_BITS'(POSITIONS - 1)) begin
            mode_r <= MODE_DIRECT;
            used   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Item, counter and result payload.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_r <= cmd;
        pos_r <= pos;
        id_r  <= state_id;
        cnt   <= '0;
        rd    <= (cmd == CMD_READ && mode_r == MODE_AIR) ? air_r : '0;
      end
      S_CLEAR:    cnt <= cnt + CNT_BITS'(1);
      S_APPEND:   idx_r <= used[PAL_AW-1:0];
      S_SRCH_RD: begin
        // Widening walks old words downward so writes never overtake reads.
        if (cnt >= used) cnt <= (mode_r == MODE_SIXTEEN) ? '0 : CNT_BITS'(POSITIONS / 2 - 1);
      end
      S_SRCH_CMP: begin
        if (pal_rdata == id_r) idx_r <= cnt[PAL_AW-1:0];
        else cnt <= cnt + CNT_BITS'(1);
      end
      S_WID_HI:   if (cnt != '0) cnt <= cnt - CNT_BITS'(1);
      S_DIR_WR:   cnt <= cnt + CNT_BITS'(1);
      S_RD_PAL:   if (CNT_BITS'(idx_ext) >= used) rd <= '0;
      S_RD_PALD:  rd <= pal_rdata;
      S_RD_DIRD:  rd <= dir_rdata;
      S_DONE: begin
        if (out_load) begin
          read_state    <= (cmd_r == CMD_READ) ? rd : '0;
          mode          <= mode_r;
          palette_count <= used;
        end
      end
      default: ;
    endcase
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for palette_packed_store_core: scoreboard-predicted reads and writes.
module tb_top;
  import pps_pkg::*;

  localparam int LIMIT = 6000000;
  localparam int PAL_TARGET = 300;

  typedef struct {
    logic [ID_BITS-1:0]  rd;
    logic [2:0]          md;
    logic [CNT_BITS-1:0] cnt;
  } store_result_t;

  class store_scoreboard;
    logic [ID_BITS-1:0] air;
    int unsigned        cur_mode;
    int unsigned        used;
    logic [ID_BITS-1:0] pal[$];
    int unsigned        idx[POSITIONS];
    logic [ID_BITS-1:0] dir_ids[POSITIONS];
    store_result_t      pending_q[$];
    int                 errors;
    int                 reads;
    int                 writes;

    function new();
      air = '0;
      cur_mode = MODE_AIR;
      used = 0;
      errors = 0;
      reads = 0;
      writes = 0;
    endfunction

    function void store_write(int unsigned p, logic [ID_BITS-1:0] id);
      int unsigned bits;
      if (cur_mode == MODE_DIRECT) begin
        dir_ids[p] = id;
        return;
      end
      if (cur_mode == MODE_AIR) begin
        if (id == air) return;
        foreach (idx[i]) idx[i] = 0;
        cur_mode = MODE_ONE;
        pal.delete();
        pal.push_back(air);
        used = 1;
      end else begin
        bits = 1 << (cur_mode - 1);
        for (int i = 0; i < used; i++) begin
          if (pal[i] == id) begin
            idx[p] = i;
            return;
          end
        end
        if (cur_mode == MODE_SIXTEEN) begin
          if (used >= PALETTE_MAX) begin
            foreach (dir_ids[i]) dir_ids[i] = pal[idx[i]];
            cur_mode = MODE_DIRECT;
            used = 0;
            pal.delete();
            dir_ids[p] = id;
            return;
          end
        end else if (used >= (1 << bits)) begin
          // widening keeps every index as it is
          cur_mode++;
        end
      end
      pal.push_back(id);
      idx[p] = used;
      used++;
    endfunction

    function void note_item(logic c, logic [POS_BITS-1:0] p, logic [ID_BITS-1:0] id);
      store_result_t r;
      r.rd = '0;
      if (c == CMD_WRITE) begin
        writes++;
        store_write(p, id);
      end else begin
        reads++;
        if (cur_mode == MODE_AIR) r.rd = air;
        else if (cur_mode == MODE_DIRECT) r.rd = dir_ids[p];
        else r.rd = pal[idx[p]];
      end
      r.md = cur_mode[2:0];
      r.cnt = used[CNT_BITS-1:0];
      pending_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    task check_result(logic [ID_BITS-1:0] rd, logic [2:0] md, logic [CNT_BITS-1:0] cnt);
      store_result_t e;
      if (pending_q.size() == 0) begin
        report("unexpected result", 32'(rd), 32'd0);
        return;
      end
      e = pending_q.pop_front();
      if (rd !== e.rd) report("read_state", 32'(rd), 32'(e.rd));
      if (md !== e.md) report("mode", 32'(md), 32'(e.md));
      if (cnt !== e.cnt) report("palette_count", 32'(cnt), 32'(e.cnt));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [ID_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic cmd;
  logic [POS_BITS-1:0] pos;
  logic [ID_BITS-1:0] state_id;
  logic out_valid;
  logic out_ready;
  logic [ID_BITS-1:0] read_state;
  logic [2:0] mode;
  logic [CNT_BITS-1:0] palette_count;

  store_scoreboard sb;
  bit quiet;
  int unsigned cycles;

  palette_packed_store_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .pos(pos), .state_id(state_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_state(read_state), .mode(mode), .palette_count(palette_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.air = cfg_data;
      if (in_valid && in_ready) sb.note_item(cmd, pos, state_id);
      if (out_valid && out_ready) sb.check_result(read_state, mode, palette_count);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // random stalls on the result side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 9);
    end
  end

  // Valid stays high after a transfer; the next call replaces the payload or drops valid.
  task send_item(logic c, logic [POS_BITS-1:0] p, logic [ID_BITS-1:0] id);
    if (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    pos <= p;
    state_id <= id;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task drain;
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task write_air(logic [ID_BITS-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task random_item;
    logic c;
    logic [POS_BITS-1:0] p;
    logic [ID_BITS-1:0] id;
    int unsigned sel;
    c = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    p = (sel < 5) ? '0 : (sel < 10) ? '1 : POS_BITS'($urandom_range(0, POSITIONS - 1));
    sel = $urandom_range(0, 99);
    if (sb.used == 0 || (sb.used < PAL_TARGET && sel < 70) || sel < 3)
      id = ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
    else if (sel < 8)
      id = sb.air;
    else
      id = sb.pal[$urandom_range(0, sb.used - 1)];
    send_item(c, p, id);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    quiet = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_READ;
    pos = '0;
    state_id = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // all-air behavior, air writes are dropped
    send_item(CMD_READ, '0, '0);
    send_item(CMD_READ, '1, 20'hFFFFF);
    send_item(CMD_WRITE, 12'd7, '0);
    write_air(20'hFFFFF);
    send_item(CMD_READ, 12'd7, '0);
    send_item(CMD_WRITE, '1, 20'hFFFFF);
    send_item(CMD_READ, '1, '0);
    write_air(20'h00005);
    // leave all-air: entry 0 takes the current air id
    send_item(CMD_WRITE, '1, '0);
    send_item(CMD_READ, '0, '0);
    send_item(CMD_READ, '1, '0);
    send_item(CMD_WRITE, '0, 20'hFFFFF);
    send_item(CMD_WRITE, 12'd1, 20'h5A5A5);
    send_item(CMD_WRITE, 12'd2, 20'hA5A5A);
    send_item(CMD_WRITE, 12'd3, 20'h00005);
    drain();
    write_air(20'h00007);
    send_item(CMD_READ, 12'd1, '0);
    send_item(CMD_READ, 12'd100, '0);
    send_item(CMD_WRITE, 12'd100, 20'h00007);
    send_item(CMD_READ, 12'd100, '0);
    send_item(CMD_READ, '0, '0);

    for (int n = 0; n < 1350; n++) begin
      if (n == 450) write_air('0);
      if (n == 900) write_air(ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1)));
      quiet = (n >= 500 && n < 700);
      random_item();
    end
    drain();

    $display("covered %0d reads and %0d writes; final mode %0d with %0d palette entries",
             sb.reads, sb.writes, sb.cur_mode, sb.used);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
